### hdl/srg_pkg.sv
package srg_pkg;

  // field and register widths
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned STEP_W    = $clog2(PROD_W);

  // default output width
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // register reset values
  localparam logic [DATA_W-1:0] AMP_RESET    = 16'd65535;
  localparam logic [DATA_W-1:0] PERIOD_RESET = 16'd100;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd1;

  // request kinds
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_ENABLE = 1'b1;

endpackage

### hdl/sawtooth_ramp_generator_unit.sv
// Sawtooth ramp generator: each tick transfer yields one sample of a rising ramp,
// amplitude * t / (period_ticks - 1), with t wrapping to 0 at period_ticks; an enable
// transfer toggles (argument 1) or stops (argument 0) the ramp and yields sample 0,
// and a stop clears t. Every input transfer yields exactly one result. A tick while
// running with period_ticks above one goes through ST_MUL (one 16x16 multiply),
// ST_DIV (the bit-serial restoring divider, one quotient bit a cycle through a
// single shared subtractor) and ST_HOLD, which loads the output register once it
// is free. Every other item goes from idle straight to ST_HOLD. Inputs are taken
// only while the sequencer is idle; a finished result waits in the output register,
// so a new item can start while it is still pending. Configuration writes are
// always ready and must only be made while the block is idle.
module sawtooth_ramp_generator_unit #(
  parameter int unsigned SAMPLE_BITS = srg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // item input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic                          in_enable_arg,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SAMPLE_BITS-1:0]        out_sample,
  output logic                          out_running,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srg_pkg::DATA_W-1:0]    cfg_data
);

  localparam int unsigned DW    = srg_pkg::DATA_W;
  localparam int unsigned PW    = srg_pkg::PROD_W;
  localparam int unsigned SW    = srg_pkg::STEP_W;
  localparam int unsigned EXT_W = (SAMPLE_BITS > DW) ? SAMPLE_BITS : DW;
  localparam logic [SW-1:0] LAST_STEP = SW'(PW - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t             state_r;
  logic [DW-1:0]      amp_r;
  logic [DW-1:0]      period_r;
  logic [DW-1:0]      tc_r;
  logic               run_r;
  logic [DW-1:0]      op_tc_r;
  logic [DW-1:0]      div_r;
  logic [DW-1:0]      rem_r;
  logic [PW-1:0]      dvd_r;
  logic [SW-1:0]      step_r;
  logic [DW-1:0]      res_r;
  logic               out_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic               out_running_r;

  logic               in_xfer;
  logic               out_free;
  logic               out_load;
  logic [DW-1:0]      tc_eff;
  logic               run_nxt;
  logic [DW:0]        shifted;
  logic [DW:0]        trial;
  logic               qbit;
  logic [DW-1:0]      rem_nxt;
  logic [PW-1:0]      dvd_nxt;
  logic [EXT_W-1:0]   res_ext;

  assign in_ready    = (state_r == ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_running = out_running_r;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == ST_HOLD) && out_free;

  // counter wrap seen by this tick
  assign tc_eff  = (tc_r >= period_r) ? '0 : tc_r;
  assign run_nxt = in_enable_arg ? !run_r : 1'b0;

  // shared divider step: one quotient bit per cycle
  assign shifted = {rem_r, dvd_r[PW-1]};
  assign trial   = shifted - {1'b0, div_r};
  assign qbit    = !trial[DW];
  assign rem_nxt = qbit ? trial[DW-1:0] : shifted[DW-1:0];
  assign dvd_nxt = {dvd_r[PW-2:0], qbit};

  assign res_ext = EXT_W'(res_r);

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      amp_r         <= srg_pkg::AMP_RESET;
      period_r      <= srg_pkg::PERIOD_RESET;
      tc_r          <= '0;
      run_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      step_r        <= '0;
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          srg_pkg::REG_AMPLITUDE: amp_r    <= cfg_data;
          srg_pkg::REG_PERIOD:    period_r <= cfg_data;
          default: ;
        endcase
      end

      // result loaded, or taken downstream
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            res_r <= '0;
            if (in_req_type == srg_pkg::REQ_TICK) begin
              if (run_r) begin
                tc_r    <= tc_eff + DW'(1);
                op_tc_r <= tc_eff;
                div_r   <= period_r - DW'(1);
                if (period_r > DW'(1)) begin
                  state_r <= ST_MUL;
                end else begin
                  state_r <= ST_HOLD;
                end
              end else begin
                state_r <= ST_HOLD;
              end
            end else begin
              run_r <= run_nxt;
              if (!run_nxt) begin
                tc_r <= '0;
              end
              state_r <= ST_HOLD;
            end
          end
        end

        ST_MUL: begin
          dvd_r   <= PW'(amp_r) * PW'(op_tc_r);
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= ST_DIV;
        end

        ST_DIV: begin
          dvd_r  <= dvd_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + SW'(1);
          if (step_r == LAST_STEP) begin
            res_r   <= dvd_nxt[DW-1:0];
            state_r <= ST_HOLD;
          end
        end

        ST_HOLD: begin
          if (out_free) begin
            out_sample_r  <= res_ext[SAMPLE_BITS-1:0];
            out_running_r <= run_r;
            state_r       <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // a stopped ramp always holds its counter at zero
  a_stopped_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> (tc_r == '0))
    else $error("time counter not cleared while stopped");

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < div_r))
    else $error("divider remainder out of range");

  // forced stop clears the run flag
  a_force_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_req_type == srg_pkg::REQ_ENABLE) && !in_enable_arg) |=> !run_r)
    else $error("stop command did not stop the ramp");

  // a tick while stopped goes straight to the output with a zero sample
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_req_type == srg_pkg::REQ_TICK) && !run_r)
      |=> ((state_r == ST_HOLD) && (res_r == '0)))
    else $error("stopped tick did not give a zero sample");

endmodule
